[rtl/armt_pkg.sv]
// shared definitions for the ack range merge tracker
// offset and length widths, the stored range entry type
// no dependencies
package armt_pkg;

    localparam int OFS_W          = 62;
    localparam int LEN_W          = 16;
    localparam int MAX_RANGES_DEF = 16;

    localparam logic [OFS_W-1:0] OFS_MASK = {OFS_W{1'b1}};

    // one stored range, hi is exclusive
    typedef struct packed {
        logic [OFS_W-1:0] lo;
        logic [OFS_W-1:0] hi;
    } entry_t;

endpackage

[rtl/armt_ram.sv]
// range table memory: two banks of entries, one write and one read port
// registered read data that holds while no read is issued
// depends on armt_pkg for the entry type
module armt_ram #(
    parameter int AW = 4
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW:0]     waddr,
    input  armt_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW:0]     raddr,
    output armt_pkg::entry_t rdata
);
    import armt_pkg::*;

    localparam int DEPTH = 2 * (2 ** AW);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ack_range_merge_tracker.sv]
// top level of the ack range merge tracker: handshakes, merge sequencer, prefix logic
// depends on armt_pkg and armt_ram
//
// Usage:
//   s_* carries one acknowledged byte range per transaction; m_* returns one
//   result per input with the acknowledged prefix, the number of stored ranges,
//   the all-acknowledged flag and the overflow flag.
//   The range table lives in a two-bank memory. A new range is merged by one
//   compare/merge unit that walks the current bank one entry per cycle (it holds
//   on an entry while the merged range is written in front of it) and writes the
//   compacted, sorted table into the other bank; the banks swap when the walk
//   ends, or stay as they were when the range is dropped. A range that inserts
//   nothing (zero length or empty after saturation) skips the walk and goes
//   straight to the prefix update; otherwise the walk reads each stored range
//   through the memory read port, then the tail write and prefix update follow.
//   s_tready is high only while the sequencer is idle.
//   A result sits in the output register until taken; the next input is
//   accepted meanwhile, and its result waits until the register frees up.
//   Reset empties the table, clears the prefix and the FIN flag and drops
//   any pending result. No memory clearing pass is needed.
module ack_range_merge_tracker #(
    parameter int MAX_RANGES = armt_pkg::MAX_RANGES_DEF,
    parameter int CW         = $clog2(MAX_RANGES + 1),
    parameter int OUT_W      = ((armt_pkg::OFS_W + CW + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    // range_start[61:0], range_length[77:62], sent_offset[139:78]
    input  logic [143:0]     s_tdata,
    // fin_acked[0], fin_on_wire[1]
    input  logic [1:0]       s_tuser,
    input  logic             s_tvalid,
    output logic             s_tready,
    // acked_prefix[61:0], range_count[61+CW:62]
    output logic [OUT_W-1:0] m_tdata,
    // all_acked[0], overflow[1]
    output logic [1:0]       m_tuser,
    output logic             m_tvalid,
    input  logic             m_tready
);
    import armt_pkg::*;

    localparam int AW = $clog2(MAX_RANGES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_PREFIX,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic             bank_reg, bank_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    w_reg, w_next;
    logic [AW-1:0]    j_reg, j_next;
    logic [OFS_W-1:0] lo_reg, lo_next;
    logic [OFS_W-1:0] hi_reg, hi_next;
    logic             placed_reg, placed_next;
    logic             hit_any_reg, hit_any_next;
    logic             head_zero_reg, head_zero_next;
    logic [OFS_W-1:0] head_hi_reg, head_hi_next;
    logic             cand_zero_reg, cand_zero_next;
    logic [OFS_W-1:0] cand_hi_reg, cand_hi_next;
    logic [OFS_W-1:0] prefix_reg, prefix_next;
    logic [OFS_W-1:0] sent_reg, sent_next;
    logic             fin_seen_reg, fin_seen_next;
    logic             fin_in_reg, fin_in_next;
    logic             drop_reg, drop_next;
    logic [OFS_W-1:0] out_prefix_reg, out_prefix_next;
    logic [CW-1:0]    out_count_reg, out_count_next;
    logic             out_done_reg, out_done_next;
    logic             out_drop_reg, out_drop_next;
    logic             m_valid_reg, m_valid_next;

    // memory ports
    logic             ram_we;
    logic [AW:0]      ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [AW:0]      ram_raddr;
    entry_t           ram_rdata;

    // input fields
    logic [OFS_W-1:0] in_start;
    logic [LEN_W-1:0] in_len;
    logic [OFS_W-1:0] in_sent;
    logic [OFS_W:0]   in_sum;
    logic [OFS_W-1:0] in_end;
    logic             in_insert;

    // compare and merge unit
    logic             cmp_hit;
    logic             cmp_below;
    logic             last_entry;
    logic             w_room;
    logic             dropped;

    armt_ram #(
        .AW (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // unpack and saturate the new range
    assign in_start  = s_tdata[OFS_W-1:0];
    assign in_len    = s_tdata[OFS_W+LEN_W-1:OFS_W];
    assign in_sent   = s_tdata[2*OFS_W+LEN_W-1:OFS_W+LEN_W];
    assign in_sum    = {1'b0, in_start} + (OFS_W + 1)'(in_len);
    assign in_end    = in_sum[OFS_W] ? OFS_MASK : in_sum[OFS_W-1:0];
    assign in_insert = (in_len != '0) && (!in_sum[OFS_W] || (in_start != OFS_MASK));

    // entry under test against the growing merged range
    assign cmp_hit    = (ram_rdata.lo <= hi_reg) && (ram_rdata.hi >= lo_reg);
    assign cmp_below  = (ram_rdata.hi < lo_reg);
    assign last_entry = ((CW'(j_reg) + CW'(1)) >= count_reg);
    assign w_room     = (w_reg < CW'(MAX_RANGES));
    assign dropped    = !hit_any_reg && (count_reg == CW'(MAX_RANGES));

    assign s_tready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        count_next      = count_reg;
        w_next          = w_reg;
        j_next          = j_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        placed_next     = placed_reg;
        hit_any_next    = hit_any_reg;
        head_zero_next  = head_zero_reg;
        head_hi_next    = head_hi_reg;
        cand_zero_next  = cand_zero_reg;
        cand_hi_next    = cand_hi_reg;
        prefix_next     = prefix_reg;
        sent_next       = sent_reg;
        fin_seen_next   = fin_seen_reg;
        fin_in_next     = fin_in_reg;
        drop_next       = drop_reg;
        out_prefix_next = out_prefix_reg;
        out_count_next  = out_count_reg;
        out_done_next   = out_done_reg;
        out_drop_next   = out_drop_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        ram_we    = 1'b0;
        ram_waddr = {!bank_reg, w_reg[AW-1:0]};
        ram_wdata = '{lo: lo_reg, hi: hi_reg};
        ram_re    = 1'b0;
        ram_raddr = {bank_reg, AW'(0)};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    lo_next      = in_start;
                    hi_next      = in_end;
                    sent_next    = in_sent;
                    fin_in_next  = s_tuser[0] | s_tuser[1];
                    placed_next  = 1'b0;
                    hit_any_next = 1'b0;
                    drop_next    = 1'b0;
                    w_next       = '0;
                    j_next       = '0;
                    if (!in_insert)
                    begin
                        state_next = ST_PREFIX;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (cmp_hit)
                begin
                    // absorb the stored entry into the merged range
                    if (ram_rdata.lo < lo_reg)
                    begin
                        lo_next = ram_rdata.lo;
                    end
                    if (ram_rdata.hi > hi_reg)
                    begin
                        hi_next = ram_rdata.hi;
                    end
                    hit_any_next = 1'b1;
                end
                else
                begin
                    // kept entry, or the merged range goes in front of it first
                    if (!cmp_below && !placed_reg)
                    begin
                        placed_next = 1'b1;
                    end
                    else
                    begin
                        ram_wdata = ram_rdata;
                    end
                    if (w_room)
                    begin
                        ram_we = 1'b1;
                        w_next = w_reg + CW'(1);
                    end
                    if (w_reg == '0)
                    begin
                        cand_zero_next = (ram_wdata.lo == '0);
                        cand_hi_next   = ram_wdata.hi;
                    end
                end

                // advance unless the kept entry still waits to be written
                if (cmp_hit || cmp_below || placed_reg)
                begin
                    if (last_entry)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = {bank_reg, j_reg + AW'(1)};
                        j_next    = j_reg + AW'(1);
                    end
                end
            end

            ST_TAIL:
            begin
                if (!placed_reg)
                begin
                    if (w_room)
                    begin
                        ram_we = 1'b1;
                    end
                    if (w_reg == '0)
                    begin
                        cand_zero_next = (lo_reg == '0);
                        cand_hi_next   = hi_reg;
                    end
                end
                drop_next = dropped;
                if (!dropped)
                begin
                    // new table becomes current
                    bank_next  = !bank_reg;
                    count_next = placed_reg ? w_reg : w_reg + CW'(1);
                    if (placed_reg || (w_reg != '0))
                    begin
                        head_zero_next = cand_zero_reg;
                        head_hi_next   = cand_hi_reg;
                    end
                    else
                    begin
                        head_zero_next = (lo_reg == '0);
                        head_hi_next   = hi_reg;
                    end
                end
                state_next = ST_PREFIX;
            end

            ST_PREFIX:
            begin
                if ((count_reg != '0) && head_zero_reg && (head_hi_reg > prefix_reg))
                begin
                    prefix_next = head_hi_reg;
                end
                fin_seen_next = fin_seen_reg | fin_in_reg;
                state_next    = ST_FINISH;
            end

            ST_FINISH:
            begin
                // load the output register once it is free
                if (!m_valid_reg || m_tready)
                begin
                    out_prefix_next = prefix_reg;
                    out_count_next  = count_reg;
                    out_done_next   = fin_seen_reg && (prefix_reg >= sent_reg);
                    out_drop_next   = drop_reg;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bank_reg       <= 1'b0;
            count_reg      <= '0;
            prefix_reg     <= '0;
            fin_seen_reg   <= 1'b0;
            head_zero_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            placed_reg     <= 1'b0;
            hit_any_reg    <= 1'b0;
            w_reg          <= '0;
            j_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            bank_reg       <= bank_next;
            count_reg      <= count_next;
            prefix_reg     <= prefix_next;
            fin_seen_reg   <= fin_seen_next;
            head_zero_reg  <= head_zero_next;
            m_valid_reg    <= m_valid_next;
            placed_reg     <= placed_next;
            hit_any_reg    <= hit_any_next;
            w_reg          <= w_next;
            j_reg          <= j_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lo_next_capture: begin
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            head_hi_reg    <= head_hi_next;
            cand_zero_reg  <= cand_zero_next;
            cand_hi_reg    <= cand_hi_next;
            sent_reg       <= sent_next;
            fin_in_reg     <= fin_in_next;
            drop_reg       <= drop_next;
            out_prefix_reg <= out_prefix_next;
            out_count_reg  <= out_count_next;
            out_done_reg   <= out_done_next;
            out_drop_reg   <= out_drop_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({out_count_reg, out_prefix_reg});
    assign m_tuser  = {out_drop_reg, out_done_reg};

`ifndef ASSERT_OFF
    // the table never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RANGES))
        else $error("range count above capacity");

    // memory writes stay inside one bank
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (w_reg < CW'(MAX_RANGES)))
        else $error("table write beyond capacity");

    // once the merged range is placed, no later entry may still overlap it
    a_no_hit_after_place: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && placed_reg |-> !cmp_hit)
        else $error("stored entry overlaps an already placed range");

    // a dropped range leaves a full table behind
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && out_drop_reg |-> (out_count_reg == CW'(MAX_RANGES)))
        else $error("overflow reported with room in the table");

    // the acknowledged prefix only grows
    a_prefix_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (prefix_reg >= $past(prefix_reg)))
        else $error("acknowledged prefix shrank");
`endif

endmodule

[verif/testbench.sv]
// self-checking testbench for ack_range_merge_tracker
// directed table then region-based random acks, checked against a range-merge predictor or fixed typed results
// depends on armt_pkg and the tracker rtl
module testbench;
    import armt_pkg::*;

    localparam int CNT_W = $clog2(MAX_RANGES_DEF + 1);
    localparam int OUT_W = ((OFS_W + CNT_W + 7) / 8) * 8;

    localparam int RAND_ITEMS = 1025;
    localparam int CALM_ITEMS = 100;
    localparam int HOLD_AT    = 300;
    localparam int LONG_HOLD  = 400;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN      = 40;
    localparam int TOP_REGION = 3;

    localparam logic [15:0] SWEEP_LEN = 16'd60000;

    // one result transaction
    typedef struct packed {
        logic [OFS_W-1:0] prefix;
        logic [CNT_W-1:0] count;
        logic             all_acked;
        logic             overflow;
    } ack_result_t;

    // one row of the directed table
    typedef struct {
        logic [OFS_W-1:0] st;
        logic [LEN_W-1:0] ln;
        logic             fa;
        logic             fw;
        logic [OFS_W-1:0] so;
        bit               typed;
        ack_result_t      res;
    } ack_row_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic [143:0]     s_tdata  = '0;
    logic [1:0]       s_tuser  = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tvalid;
    logic             m_tready = 1'b0;

    // predicted range table, prefix and fin state
    logic [OFS_W-1:0] tbl_lo [MAX_RANGES_DEF];
    logic [OFS_W-1:0] tbl_hi [MAX_RANGES_DEF];
    int               tbl_count = 0;
    logic [OFS_W-1:0] prefix_q  = '0;
    logic             fin_q     = 1'b0;

    ack_result_t pending_results [$];
    ack_row_t    dir_rows [$];

    bit          cur_typed = 1'b0;
    ack_result_t cur_exp   = '0;
    bit          calm       = 1'b0;
    bit          hold_start = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          mismatches = 0;

    ack_range_merge_tracker u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #10 clk = ~clk;

    // merge [lo, hi) into the predicted table, returns 1 when the range is dropped
    function automatic logic merge_range(input logic [OFS_W-1:0] lo_in,
                                         input logic [OFS_W-1:0] hi_in);
        logic [OFS_W-1:0] nlo [MAX_RANGES_DEF+1];
        logic [OFS_W-1:0] nhi [MAX_RANGES_DEF+1];
        logic [OFS_W-1:0] lo;
        logic [OFS_W-1:0] hi;
        int kept;
        int hits;
        int pos;
        lo = lo_in;
        hi = hi_in;
        kept = 0;
        hits = 0;
        // absorb every entry that overlaps or touches, keep the rest in order
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_lo[i] <= hi && tbl_hi[i] >= lo)
            begin
                if (tbl_lo[i] < lo)
                    lo = tbl_lo[i];
                if (tbl_hi[i] > hi)
                    hi = tbl_hi[i];
                hits++;
            end
            else
            begin
                nlo[kept] = tbl_lo[i];
                nhi[kept] = tbl_hi[i];
                kept++;
            end
        end
        if (hits == 0 && kept >= MAX_RANGES_DEF)
            return 1'b1;
        // sorted insert of the merged range
        pos = 0;
        while (pos < kept && nlo[pos] < lo)
            pos++;
        for (int i = kept; i > pos; i--)
        begin
            nlo[i] = nlo[i-1];
            nhi[i] = nhi[i-1];
        end
        nlo[pos] = lo;
        nhi[pos] = hi;
        kept++;
        for (int i = 0; i < kept; i++)
        begin
            tbl_lo[i] = nlo[i];
            tbl_hi[i] = nhi[i];
        end
        tbl_count = kept;
        return 1'b0;
    endfunction

    // advance the predicted state by one ack and form its result
    function automatic ack_result_t apply_ack(input logic [OFS_W-1:0] st,
                                              input logic [LEN_W-1:0] ln,
                                              input logic fa, input logic fw,
                                              input logic [OFS_W-1:0] so);
        ack_result_t r;
        logic [OFS_W:0]   sum;
        logic [OFS_W-1:0] top;
        logic             dropped;
        dropped = 1'b0;
        if (ln != '0)
        begin
            // end saturates at the top of the offset space
            sum = {1'b0, st} + (OFS_W + 1)'(ln);
            top = (sum > {1'b0, OFS_MASK}) ? OFS_MASK : sum[OFS_W-1:0];
            if (top > st)
                dropped = merge_range(st, top);
        end
        if (tbl_count > 0 && tbl_lo[0] == '0 && tbl_hi[0] > prefix_q)
            prefix_q = tbl_hi[0];
        if (fa || fw)
            fin_q = 1'b1;
        r.prefix    = prefix_q;
        r.count     = tbl_count[CNT_W-1:0];
        r.all_acked = fin_q && (prefix_q >= so);
        r.overflow  = dropped;
        return r;
    endfunction

    function automatic logic [OFS_W-1:0] rnd_offset();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[OFS_W-1:0];
    endfunction

    function automatic void add_row(input logic [OFS_W-1:0] st, input logic [LEN_W-1:0] ln,
                                    input logic fa, input logic fw,
                                    input logic [OFS_W-1:0] so, input bit typed,
                                    input ack_result_t res);
        ack_row_t row;
        row.st    = st;
        row.ln    = ln;
        row.fa    = fa;
        row.fw    = fw;
        row.so    = so;
        row.typed = typed;
        row.res   = res;
        dir_rows.push_back(row);
    endfunction

    // offer one ack transaction, called and returning at a falling edge
    task automatic send_ack(input logic [OFS_W-1:0] st, input logic [LEN_W-1:0] ln,
                            input logic fa, input logic fw, input logic [OFS_W-1:0] so);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, so, ln, st};
        s_tuser  <= {fw, fa};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: random stall bursts plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // predict on accepted input, check on accepted output
    always @(posedge clk)
    begin
        ack_result_t want;
        ack_result_t got;
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                want = apply_ack(s_tdata[61:0], s_tdata[77:62], s_tuser[0], s_tuser[1],
                                 s_tdata[139:78]);
                if (cur_typed)
                    want = cur_exp;
                pending_results.push_back(want);
                moved = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                got.prefix    = m_tdata[OFS_W-1:0];
                got.count     = m_tdata[OFS_W+CNT_W-1:OFS_W];
                got.all_acked = m_tuser[0];
                got.overflow  = m_tuser[1];
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, got prefix %h count %0d", $time,
                             got.prefix, got.count);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.prefix != want.prefix)
                    begin
                        $display("%0t: acked_prefix expected %h got %h", $time,
                                 want.prefix, got.prefix);
                        mismatches++;
                    end
                    if (got.count != want.count)
                    begin
                        $display("%0t: range_count expected %0d got %0d", $time,
                                 want.count, got.count);
                        mismatches++;
                    end
                    if (got.all_acked != want.all_acked)
                    begin
                        $display("%0t: all_acked expected %b got %b", $time,
                                 want.all_acked, got.all_acked);
                        mismatches++;
                    end
                    if (got.overflow != want.overflow)
                    begin
                        $display("%0t: overflow expected %b got %b", $time,
                                 want.overflow, got.overflow);
                        mismatches++;
                    end
                end
            end
        end
        if (moved)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // watchdog on cycles without any transaction
    initial
    begin
        while (quiet_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [OFS_W-1:0] st;
        logic [OFS_W-1:0] so;
        logic [OFS_W-1:0] base;
        logic [OFS_W-1:0] chain_end;
        logic [LEN_W-1:0] ln;
        logic             fa;
        logic             fw;
        int               region_left;
        int               region_no;
        int               pick;
        bit               top_region;

        // directed table: reset state, saturation, fin, filling, overflow, merges
        add_row(62'd0, 16'd0, 1'b0, 1'b0, 62'd0, 1'b1, '{62'd0, 5'd0, 1'b0, 1'b0});
        add_row(62'd100, 16'd50, 1'b0, 1'b0, 62'd1000, 1'b0, '0);
        add_row(62'd0, 16'd100, 1'b0, 1'b0, 62'd1000, 1'b0, '0);
        add_row(OFS_MASK, 16'hFFFF, 1'b0, 1'b0, 62'd0, 1'b1, '{62'd150, 5'd1, 1'b0, 1'b0});
        add_row(OFS_MASK - 62'd10, 16'hFFFF, 1'b0, 1'b0, OFS_MASK, 1'b0, '0);
        add_row(OFS_MASK - 62'd1, 16'd1, 1'b0, 1'b0, 62'd0, 1'b0, '0);
        add_row(62'd200, 16'd0, 1'b1, 1'b0, 62'd150, 1'b1, '{62'd150, 5'd2, 1'b1, 1'b0});
        add_row(62'd300, 16'd0, 1'b0, 1'b1, 62'd151, 1'b0, '0);
        for (int k = 1; k <= 14; k++)
            add_row(62'(k * 1000), 16'd10, 1'b0, 1'b0, OFS_MASK, 1'b0, '0);
        add_row(62'd20000, 16'd10, 1'b0, 1'b0, 62'd0, 1'b1, '{62'd150, 5'd16, 1'b1, 1'b1});
        add_row(62'd1010, 16'd1, 1'b0, 1'b0, 62'd0, 1'b0, '0);
        add_row(62'd1005, 16'd2000, 1'b0, 1'b0, 62'd5000, 1'b0, '0);
        add_row(62'd0, 16'hFFFF, 1'b1, 1'b1, 62'd65535, 1'b0, '0);

        // reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            cur_typed = dir_rows[i].typed;
            cur_exp   = dir_rows[i].res;
            send_ack(dir_rows[i].st, dir_rows[i].ln, dir_rows[i].fa, dir_rows[i].fw,
                     dir_rows[i].so);
        end
        cur_typed = 1'b0;

        // random part: fragments inside a window, then a sweep that collapses them
        chain_end   = 62'd65535;
        region_left = $urandom_range(60, 110);
        region_no   = 0;
        top_region  = 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == HOLD_AT)
                hold_start = 1'b1;
            if (n == RAND_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            base = top_region ? OFS_MASK - OFS_W'(SWEEP_LEN) : chain_end;
            fa   = ($urandom_range(0, 39) == 0);
            fw   = ($urandom_range(0, 39) == 0);
            pick = $urandom_range(0, 99);
            if (region_left == 0)
            begin
                st = base;
                ln = SWEEP_LEN;
                if (!top_region)
                    chain_end = chain_end + OFS_W'(SWEEP_LEN);
                region_no++;
                top_region  = (region_no == TOP_REGION);
                region_left = $urandom_range(60, 110);
            end
            else
            begin
                region_left--;
                if (pick < 6)
                begin
                    // zero length anywhere in the offset space
                    st = rnd_offset();
                    ln = '0;
                end
                else if (pick < 10)
                begin
                    // empty after saturation
                    st = OFS_MASK;
                    ln = LEN_W'($urandom_range(0, 65535));
                end
                else if (pick < 16)
                begin
                    st = base + OFS_W'($urandom_range(0, SWEEP_LEN));
                    ln = LEN_W'($urandom_range(0, 65535));
                end
                else
                begin
                    st = base + OFS_W'($urandom_range(0, SWEEP_LEN));
                    ln = LEN_W'($urandom_range(0, 300));
                end
            end
            // sent offset around the prefix so all_acked goes both ways
            pick = $urandom_range(0, 9);
            if (pick < 4)
                so = prefix_q - OFS_W'($urandom_range(0, 500));
            else if (pick < 8)
                so = prefix_q + OFS_W'($urandom_range(1, 500));
            else
                so = rnd_offset();
            send_ack(st, ln, fa, fw, so);
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
